/* src/amgdfs_pkg.sv */
// Package for the adjacency matrix graph search core.
// Holds the operation codes, the fixed field widths and the result type.
// No dependencies.
package amgdfs_pkg;

    localparam int ID_W        = 16;
    localparam int VALUE_W     = 16;
    localparam int COUNT_W     = 10;
    localparam int MAX_RESULTS = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

    typedef enum logic [2:0] {
        OP_INSERT_NODE = 3'd0,
        OP_INSERT_EDGE = 3'd1,
        OP_CONNECTED   = 3'd2,
        OP_COUNT       = 3'd3,
        OP_NEIGHBORS   = 3'd4,
        OP_SEARCH      = 3'd5
    } op_t;

    typedef struct packed {
        logic               status;
        logic               flag;
        logic [VALUE_W-1:0] value;
        logic               last;
    } result_t;

endpackage

/* src/amgdfs_req_if.sv */
// Request channel of the graph search core.
// Depends on amgdfs_pkg for the field widths.
interface amgdfs_req_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 op;
    logic [amgdfs_pkg::ID_W-1:0] id_a;
    logic [amgdfs_pkg::ID_W-1:0] id_b;

    modport source (output valid, output op, output id_a, output id_b, input ready);
    modport sink (input valid, input op, input id_a, input id_b, output ready);
endinterface

/* src/amgdfs_rsp_if.sv */
// Result channel of the graph search core.
// Depends on amgdfs_pkg for the field widths.
interface amgdfs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          status;
    logic                          flag;
    logic [amgdfs_pkg::VALUE_W-1:0] value;
    logic                          last;

    modport source (output valid, output status, output flag, output value, output last,
                    input ready);
    modport sink (input valid, input status, input flag, input value, input last,
                  output ready);
endinterface

/* src/adjacency_matrix_graph_dfs_core.sv */
// Top level of the adjacency matrix graph search core.
// Depends on amgdfs_pkg, amgdfs_req_if, amgdfs_rsp_if and amgdfs_ram.

// One request is taken at a time and the core is not ready until its last result has been
// taken. The id lookup scans the stored nodes of the node table through its RAM port,
// then the operation runs: inserts write the tables and queries read them,
// a neighbor list scans the row positions up to the last neighbor and gives one result per
// neighbor, and a search pops stacked nodes and scans the row of each unvisited one up to
// its last neighbor. Every result is held in the output stage until it is taken. No
// clearing pass runs after reset.
module adjacency_matrix_graph_dfs_core #(
    parameter int MAX_NODES   = 32,
    parameter int STACK_DEPTH = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    amgdfs_req_if.sink   req,
    amgdfs_rsp_if.source rsp
);

    import amgdfs_pkg::*;

    localparam int IW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int KW  = $clog2(MAX_RESULTS);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_FRD   = 13'b0000000000010,
        ST_FCMP  = 13'b0000000000100,
        ST_DISP  = 13'b0000000001000,
        ST_AUSE  = 13'b0000000010000,
        ST_LSCAN = 13'b0000000100000,
        ST_LRD   = 13'b0000001000000,
        ST_SPOP  = 13'b0000010000000,
        ST_SPOPW = 13'b0000100000000,
        ST_SROW  = 13'b0001000000000,
        ST_SSCAN = 13'b0010000000000,
        ST_OUTW  = 13'b0100000000000,
        ST_OUTL  = 13'b1000000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [2:0]             op_reg, op_next;
    logic [ID_W-1:0]        a_reg, a_next;
    logic [ID_W-1:0]        b_reg, b_next;
    logic [CW-1:0]          i_reg, i_next;
    logic                   fa_reg, fa_next, fb_reg, fb_next;
    logic [IW-1:0]          ia_reg, ia_next, ib_reg, ib_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [MAX_NODES-1:0]   row_reg, row_next;
    logic [IW-1:0]          j_reg, j_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [SPW-1:0]         sp_reg, sp_next;
    logic [MAX_NODES-1:0]   visit_reg, visit_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    logic                   ids_we, adj_we, cnt_we, stk_we;
    logic [IW-1:0]          ids_waddr, ids_raddr, adj_waddr, adj_raddr;
    logic [ID_W-1:0]        ids_rdata;
    logic [MAX_NODES-1:0]   adj_wdata, adj_rdata, row_cleared;
    logic [COUNT_W-1:0]     cnt_wdata, cnt_rdata;
    logic [SAW-1:0]         stk_waddr, stk_raddr;
    logic [IW-1:0]          stk_wdata, stk_rdata;
    logic                   list_last;

    amgdfs_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_ids (
        .clk(clk), .we(ids_we), .waddr(ids_waddr), .wdata(a_reg),
        .raddr(ids_raddr), .rdata(ids_rdata)
    );
    amgdfs_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj (
        .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
        .raddr(adj_raddr), .rdata(adj_rdata)
    );
    amgdfs_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(adj_waddr), .wdata(cnt_wdata),
        .raddr(adj_raddr), .rdata(cnt_rdata)
    );
    amgdfs_ram #(.WIDTH(IW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    assign req.ready  = (state_reg == ST_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_reg.status;
    assign rsp.flag   = out_reg.flag;
    assign rsp.value  = out_reg.value;
    assign rsp.last   = out_reg.last;

    assign row_cleared = row_reg & ~(MAX_NODES'(1) << j_reg);
    assign list_last   = (row_cleared == '0) || (k_reg == KW'(MAX_RESULTS - 1));

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        i_next         = i_reg;
        fa_next        = fa_reg;
        fb_next        = fb_reg;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        count_next     = count_reg;
        row_next       = row_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        sp_next        = sp_reg;
        visit_next     = visit_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        ids_we    = 1'b0;
        ids_waddr = count_reg[IW-1:0];
        ids_raddr = i_reg[IW-1:0];
        adj_we    = 1'b0;
        cnt_we    = 1'b0;
        adj_waddr = count_reg[IW-1:0];
        adj_wdata = '0;
        cnt_wdata = '0;
        adj_raddr = ia_reg;
        stk_we    = 1'b0;
        stk_waddr = SAW'(sp_reg);
        stk_wdata = ia_reg;
        stk_raddr = SAW'(sp_reg - 1'b1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.op;
                    a_next     = req.id_a;
                    b_next     = req.id_b;
                    i_next     = '0;
                    fa_next    = 1'b0;
                    fb_next    = 1'b0;
                    state_next = ST_FRD;
                end
            end
            ST_FRD:
            begin
                state_next = (i_reg == count_reg) ? ST_DISP : ST_FCMP;
            end
            ST_FCMP:
            begin
                if (ids_rdata == a_reg)
                begin
                    fa_next = 1'b1;
                    ia_next = i_reg[IW-1:0];
                end
                if (ids_rdata == b_reg)
                begin
                    fb_next = 1'b1;
                    ib_next = i_reg[IW-1:0];
                end
                i_next     = i_reg + 1'b1;
                state_next = ST_FRD;
            end
            ST_DISP:
            begin
                out_next   = '{status: 1'b1, flag: 1'b0, value: '0, last: 1'b1};
                state_next = ST_OUTW;
                case (op_reg) inside
                    OP_INSERT_NODE:
                    begin
                        if (!fa_reg && count_reg != CW'(MAX_NODES))
                        begin
                            ids_we          = 1'b1;
                            adj_we          = 1'b1;
                            cnt_we          = 1'b1;
                            count_next      = count_reg + 1'b1;
                            out_next.status = 1'b0;
                        end
                    end
                    OP_INSERT_EDGE, OP_CONNECTED:
                    begin
                        if (fa_reg && fb_reg)
                        begin
                            state_next = ST_AUSE;
                        end
                    end
                    OP_COUNT, OP_NEIGHBORS:
                    begin
                        if (fa_reg)
                        begin
                            state_next = ST_AUSE;
                        end
                    end
                    OP_SEARCH:
                    begin
                        if (fa_reg && fb_reg)
                        begin
                            visit_next = '0;
                            stk_we     = 1'b1;
                            stk_waddr  = '0;
                            stk_wdata  = ia_reg;
                            sp_next    = SPW'(1);
                            state_next = ST_SPOP;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                out_valid_next = (state_next == ST_OUTW);
            end
            ST_AUSE:
            begin
                out_next   = '{status: 1'b0, flag: 1'b0, value: '0, last: 1'b1};
                state_next = ST_OUTW;
                case (op_reg)
                    OP_INSERT_EDGE:
                    begin
                        adj_we    = 1'b1;
                        cnt_we    = 1'b1;
                        adj_waddr = ia_reg;
                        adj_wdata = adj_rdata | (MAX_NODES'(1) << ib_reg);
                        cnt_wdata = (cnt_rdata < COUNT_MAX) ? cnt_rdata + 1'b1 : cnt_rdata;
                    end
                    OP_CONNECTED:
                    begin
                        out_next.flag = adj_rdata[ib_reg];
                    end
                    OP_COUNT:
                    begin
                        out_next.value = VALUE_W'(cnt_rdata);
                    end
                    default:
                    begin
                        row_next   = adj_rdata;
                        j_next     = '0;
                        k_next     = '0;
                        state_next = ST_LSCAN;
                    end
                endcase
                out_valid_next = (state_next == ST_OUTW);
            end
            ST_LSCAN:
            begin
                ids_raddr = j_reg;
                if (row_reg == '0)
                begin
                    out_next       = '{status: 1'b0, flag: 1'b0, value: '0, last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = ST_OUTW;
                end
                else if (row_reg[j_reg])
                begin
                    state_next = ST_LRD;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_LRD:
            begin
                out_next       = '{status: 1'b0, flag: 1'b1, value: VALUE_W'(ids_rdata),
                                   last: list_last};
                out_valid_next = 1'b1;
                row_next       = row_cleared;
                j_next         = j_reg + 1'b1;
                k_next         = k_reg + 1'b1;
                state_next     = list_last ? ST_OUTW : ST_OUTL;
            end
            ST_SPOP:
            begin
                if (sp_reg == '0)
                begin
                    out_next       = '{status: 1'b0, flag: 1'b0, value: '0, last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = ST_OUTW;
                end
                else
                begin
                    sp_next    = sp_reg - 1'b1;
                    state_next = ST_SPOPW;
                end
            end
            ST_SPOPW:
            begin
                adj_raddr = stk_rdata;
                if (visit_reg[stk_rdata])
                begin
                    state_next = ST_SPOP;
                end
                else
                begin
                    visit_next[stk_rdata] = 1'b1;
                    state_next            = ST_SROW;
                end
            end
            ST_SROW:
            begin
                row_next   = adj_rdata;
                j_next     = '0;
                state_next = ST_SSCAN;
            end
            ST_SSCAN:
            begin
                stk_wdata = j_reg;
                if (row_reg == '0)
                begin
                    state_next = ST_SPOP;
                end
                else
                begin
                    if (row_reg[j_reg])
                    begin
                        if (j_reg == ib_reg)
                        begin
                            out_next       = '{status: 1'b0, flag: 1'b1, value: '0,
                                               last: 1'b1};
                            out_valid_next = 1'b1;
                            state_next     = ST_OUTW;
                        end
                        else if (!visit_reg[j_reg] && sp_reg != SPW'(STACK_DEPTH))
                        begin
                            stk_we  = 1'b1;
                            sp_next = sp_reg + 1'b1;
                        end
                    end
                    row_next = row_cleared;
                    j_next   = j_reg + 1'b1;
                end
            end
            ST_OUTW:
            begin
                if (rsp.ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            ST_OUTL:
            begin
                if (rsp.ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_LSCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        i_reg     <= i_next;
        fa_reg    <= fa_next;
        fb_reg    <= fb_next;
        ia_reg    <= ia_next;
        ib_reg    <= ib_next;
        row_reg   <= row_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        sp_reg    <= sp_next;
        visit_reg <= visit_next;
        out_reg   <= out_next;
    end

endmodule

/* src/amgdfs_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module amgdfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* verif/tb_amgdfs_scoreboard.sv */
// Scoreboard class for the graph search core testbench.
// Holds a predictor of the node table, adjacency matrix and counts; depends on amgdfs_pkg.
package tb_amgdfs_scoreboard_pkg;
    import amgdfs_pkg::*;

    localparam int NODES = 32;
    localparam int STACK_SIZE = 1024;

    class graph_scoreboard;
        logic [ID_W-1:0]    ids [NODES];
        int                 node_total;
        logic [NODES-1:0]   rows [NODES];
        logic [COUNT_W-1:0] counts [NODES];
        result_t            pending [$];
        int                 errors;

        function new();
            node_total = 0;
            errors = 0;
            for (int i = 0; i < NODES; i++)
            begin
                ids[i] = '0;
                rows[i] = '0;
                counts[i] = '0;
            end
        endfunction

        function int lookup(logic [ID_W-1:0] id);
            for (int i = 0; i < node_total; i++)
                if (ids[i] == id)
                    return i;
            return -1;
        endfunction

        function void push_result(logic st, logic fl, logic [VALUE_W-1:0] val, logic lst);
            result_t r;
            r.status = st;
            r.flag = fl;
            r.value = val;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function logic dfs_reaches(int start, logic [ID_W-1:0] target);
            int stack [$];
            logic [NODES-1:0] seen;
            int n;
            seen = '0;
            stack.push_back(start);
            while (stack.size() > 0)
            begin
                n = stack.pop_back();
                if (seen[n])
                    continue;
                seen[n] = 1'b1;
                for (int j = 0; j < node_total; j++)
                begin
                    if (!rows[n][j])
                        continue;
                    if (ids[j] == target)
                        return 1'b1;
                    if (!seen[j] && stack.size() < STACK_SIZE)
                        stack.push_back(j);
                end
            end
            return 1'b0;
        endfunction

        function void note_request(logic [2:0] op, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
            int ia;
            int ib;
            int k;
            ia = lookup(a);
            ib = lookup(b);
            case (op)
                OP_INSERT_NODE:
                begin
                    if (ia >= 0 || node_total >= NODES)
                        push_result(1, 0, 0, 1);
                    else
                    begin
                        ids[node_total] = a;
                        rows[node_total] = '0;
                        counts[node_total] = '0;
                        node_total++;
                        push_result(0, 0, 0, 1);
                    end
                end
                OP_INSERT_EDGE:
                begin
                    if (ia < 0 || ib < 0)
                        push_result(1, 0, 0, 1);
                    else
                    begin
                        rows[ia][ib] = 1'b1;
                        if (counts[ia] < COUNT_MAX)
                            counts[ia]++;
                        push_result(0, 0, 0, 1);
                    end
                end
                OP_CONNECTED:
                    if (ia < 0 || ib < 0)
                        push_result(1, 0, 0, 1);
                    else
                        push_result(0, rows[ia][ib], 0, 1);
                OP_COUNT:
                    if (ia < 0)
                        push_result(1, 0, 0, 1);
                    else
                        push_result(0, 0, VALUE_W'(counts[ia]), 1);
                OP_NEIGHBORS:
                begin
                    if (ia < 0)
                        push_result(1, 0, 0, 1);
                    else
                    begin
                        k = 0;
                        for (int j = 0; j < node_total && k < MAX_RESULTS; j++)
                            if (rows[ia][j])
                            begin
                                push_result(0, 1, ids[j], 0);
                                k++;
                            end
                        if (k == 0)
                            push_result(0, 0, 0, 1);
                        else
                            pending[pending.size()-1].last = 1'b1;
                    end
                end
                OP_SEARCH:
                    if (ia < 0 || ib < 0)
                        push_result(1, 0, 0, 1);
                    else
                        push_result(0, dfs_reaches(ia, b), 0, 1);
                default:
                    push_result(1, 0, 0, 1);
            endcase
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("error: %s got %0h want %0h", what, got, want);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result", got, 0);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.flag !== want.flag)
                report("flag", got.flag, want.flag);
            if (got.value !== want.value)
                report("value", got.value, want.value);
            if (got.last !== want.last)
                report("last", got.last, want.last);
        endtask
    endclass
endpackage

/* verif/tb_top.sv */
// Top module of the graph search core testbench.
// Drives requests with random gaps and checks results; depends on the scoreboard package.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import amgdfs_pkg::*;
    import tb_amgdfs_scoreboard_pkg::*;

    logic clk;
    logic rst_n;
    amgdfs_req_if req ();
    amgdfs_rsp_if rsp ();
    graph_scoreboard sb;
    logic [ID_W-1:0] known_ids [$];
    int hold_cycles;
    bit stim_done;

    adjacency_matrix_graph_dfs_core dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    task send_request(logic [2:0] op, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op <= op;
        req.id_a <= a;
        req.id_b <= b;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(op, a, b);
        if (op == OP_INSERT_NODE)
            known_ids.push_back(a);
    endtask

    function logic [ID_W-1:0] pick_id();
        if (known_ids.size() == 0 || $urandom_range(0, 9) == 0)
            return ID_W'($urandom);
        return known_ids[$urandom_range(0, known_ids.size() - 1)];
    endfunction

    task wait_drained();
        req.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        #20000000;
        $display("adjacency_matrix_graph_dfs_core: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
            sb.check_result(result_t'({rsp.status, rsp.flag, rsp.value, rsp.last}));
    end

    initial
    begin
        rsp.ready = 1'b0;
        hold_cycles = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp.ready <= 1'b0;
            end
            else if (stim_done)
                rsp.ready <= 1'b1;
            else if ($urandom_range(0, 39) == 0)
            begin
                hold_cycles = $urandom_range(10, 60);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        logic [2:0] op;
        logic [ID_W-1:0] a;
        sb = new();
        stim_done = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.op = '0;
        req.id_a = '0;
        req.id_b = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_COUNT, 16'h0000, 16'h0000);
        send_request(OP_INSERT_NODE, 16'h0000, 16'hffff);
        send_request(OP_INSERT_NODE, 16'hffff, 16'h0000);
        send_request(OP_INSERT_NODE, 16'h0000, 16'h0000);
        send_request(OP_NEIGHBORS, 16'h0000, 16'h0000);
        send_request(OP_INSERT_EDGE, 16'h0000, 16'hffff);
        send_request(OP_INSERT_EDGE, 16'h0000, 16'hffff);
        send_request(OP_INSERT_EDGE, 16'h1234, 16'hffff);
        send_request(OP_CONNECTED, 16'h0000, 16'hffff);
        send_request(OP_CONNECTED, 16'hffff, 16'h0000);
        send_request(OP_COUNT, 16'h0000, 16'h0000);
        send_request(OP_SEARCH, 16'h0000, 16'h0000);
        send_request(OP_INSERT_EDGE, 16'hffff, 16'hffff);
        send_request(OP_SEARCH, 16'hffff, 16'hffff);
        send_request(OP_SEARCH, 16'h0000, 16'h0000);
        send_request(OP_SEARCH, 16'h0000, 16'h5555);
        send_request(3'd6, 16'h0000, 16'h0000);
        send_request(3'd7, 16'hffff, 16'hffff);
        for (int i = 2; i < 33; i++)
            send_request(OP_INSERT_NODE, ID_W'(16'h0100 + i), 16'h0000);
        for (int i = 0; i < 32; i++)
            send_request(OP_INSERT_EDGE, 16'h0000, known_ids[i]);
        send_request(OP_NEIGHBORS, 16'h0000, 16'h0000);

        wait_drained();
        hold_cycles = 400;
        for (int i = 0; i < 20; i++)
            send_request(OP_COUNT, pick_id(), 16'h0000);
        wait_drained();
        repeat (300) @(posedge clk);

        for (int i = 0; i < 220; i++)
        begin
            op = 3'($urandom_range(0, 5));
            if ($urandom_range(0, 49) == 0)
                op = 3'($urandom_range(6, 7));
            if (op == OP_INSERT_EDGE && $urandom_range(0, 2) == 0)
            begin
                a = pick_id();
                for (int k = 0; k < 4; k++)
                    send_request(OP_INSERT_EDGE, a, pick_id());
            end
            else
                send_request(op, pick_id(), pick_id());
            if (i == 110)
            begin
                wait_drained();
                repeat (300) @(posedge clk);
            end
        end

        stim_done = 1'b1;
        wait_drained();
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("adjacency_matrix_graph_dfs_core: match");
        else
            $display("adjacency_matrix_graph_dfs_core: mismatch");
        $finish;
    end
endmodule

/* sim.f */
src/amgdfs_pkg.sv
src/amgdfs_req_if.sv
src/amgdfs_rsp_if.sv
src/amgdfs_ram.sv
src/adjacency_matrix_graph_dfs_core.sv
verif/tb_amgdfs_scoreboard.sv
verif/tb_top.sv
